// ----- hw/rtl/great_circle_distance_top_assert.svh -----
// assertion macros for the great-circle distance block
`ifndef GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define GCD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gcd assertion failed");
`define GCD_ASSERT_NEXT(lbl, cond, conseq) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("gcd assertion failed");
`else
`define GCD_ASSERT(lbl, prop)
`define GCD_ASSERT_NEXT(lbl, cond, conseq)
`endif

`endif

// ----- hw/rtl/gcd_pkg.sv -----
package gcd_pkg;

	typedef logic signed [29:0] lat_t;
	typedef logic signed [30:0] lon_t;
	typedef logic [30:0] dist_t;
	typedef logic signed [33:0] ang_t;

	// degrees in q23
	localparam ang_t DEG_FULL    = 34'sd3019898880;
	localparam ang_t DEG_HALF    = 34'sd1509949440;
	localparam ang_t DEG_QUARTER = 34'sd754974720;

	localparam logic [29:0] PI_Q28   = 30'd843314857;
	localparam logic [59:0] RAD_RND  = 60'd188743680;
	// floor(2^37 / 45)
	localparam logic [31:0] RECIP45  = 32'd3054198966;
	localparam ang_t        CORDIC_K = 34'sd652032874;
	localparam logic [30:0] ONE_Q30  = 31'd1073741824;
	localparam logic [13:0] DIAM_KM  = 14'd12742;
	localparam dist_t MAX_DIST = 31'((64'd843314857 * 64'd6371 + 64'd2048) >> 12);

	function automatic ang_t atan_step(input int i);
		ang_t v;
		unique case (i)
			0: v = 34'sd843314856;
			1: v = 34'sd497837829;
			2: v = 34'sd263043836;
			3: v = 34'sd133525158;
			4: v = 34'sd67021686;
			5: v = 34'sd33543515;
			6: v = 34'sd16775850;
			7: v = 34'sd8388437;
			8: v = 34'sd4194282;
			9: v = 34'sd2097149;
			10: v = 34'sd1048575;
			default: begin
				if (i < 30) v = 34'((64'sd1 <<< (30 - i)) - 64'sd1);
				else v = '0;
			end
		endcase
		return v;
	endfunction

endpackage

// ----- hw/rtl/gcd_pair_if.sv -----
interface gcd_pair_if;
	import gcd_pkg::*;
	logic valid;
	logic ready;
	lat_t lat_a;
	lon_t lon_a;
	lat_t lat_b;
	lon_t lon_b;
	modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
	modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

// ----- hw/rtl/gcd_dist_if.sv -----
interface gcd_dist_if;
	import gcd_pkg::*;
	logic valid;
	logic ready;
	dist_t distance_km;
	modport source (output valid, distance_km, input ready);
	modport sink (input valid, distance_km, output ready);
endinterface

// ----- hw/rtl/great_circle_distance_top.sv -----
// channel | dir | fields                          | beat
// pair    | in  | lat_a, lon_a, lat_b, lon_b      | one point pair, degrees q22
// res     | out | distance_km                     | one distance, km q16
//
// latency is set by the two cordic chains and the 31-stage square-root
// pipeline; one beat is taken every cycle while res is not stalled
// reset clears only the valid bits of the pipeline; no clearing pass
// a stall on res freezes the whole pipeline at once, so nothing is lost or
// repeated; pair.ready is low only while the output holds an untaken beat
`include "great_circle_distance_top_assert.svh"

module great_circle_distance_top #(
	parameter int CORDIC_STEPS = 24
) (
	input logic clk,
	input logic arst_n,
	gcd_pair_if.sink pair,
	gcd_dist_if.source res
);
	import gcd_pkg::*;

	localparam int N = CORDIC_STEPS;
	localparam int SQ = 31;

	logic en;

	// angle front end, four lanes:
	// dlat half, dlon half, lat_a, lat_b (all degrees q23)
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	ang_t d_s1 [4];
	logic [29:0] m_s2 [4];
	logic neg_s2 [4], nc_s2 [4];
	logic [59:0] p_s3 [4];
	logic neg_s3 [4], nc_s3 [4];
	logic [36:0] t_s4 [4];
	logic neg_s4 [4], nc_s4 [4];
	logic [36:0] t_s5 [4];
	logic [31:0] e_s5 [4];
	logic neg_s5 [4], nc_s5 [4];

	// rotation cordic
	logic rot_v_s [0:N];
	ang_t rot_x_s [0:N][4];
	ang_t rot_y_s [0:N][4];
	ang_t rot_z_s [0:N][4];
	logic rot_nc_s [0:N][4];

	// haversine products
	logic v_m1, v_m2;
	logic [33:0] u2_m1, v2_m1, u2_m2;
	ang_t cc_m1, t2_m2;

	// square roots of h and 1-h
	logic sq_v_s [0:SQ];
	logic [60:0] sq_n1_s [0:SQ];
	logic [60:0] sq_n2_s [0:SQ];
	logic [61:0] sq_r1_s [0:SQ];
	logic [61:0] sq_r2_s [0:SQ];

	// vectoring cordic
	logic vec_v_s [0:N];
	ang_t vec_x_s [0:N];
	ang_t vec_y_s [0:N];
	ang_t vec_z_s [0:N];

	logic v_d1;
	logic [45:0] dp_d1;
	logic out_v_q;
	dist_t out_dist_q;

	// whole pipeline advances unless the output beat is held
	assign en = !out_v_q || res.ready;
	assign pair.ready = en;
	assign res.valid = out_v_q;
	assign res.distance_km = out_dist_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_d1 <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 0; k <= N; k++) begin
				rot_v_s[k] <= 1'b0;
				vec_v_s[k] <= 1'b0;
			end
			for (int k = 0; k <= SQ; k++) sq_v_s[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= pair.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			rot_v_s[0] <= v_s5;
			for (int k = 0; k < N; k++) rot_v_s[k+1] <= rot_v_s[k];
			v_m1 <= rot_v_s[N];
			v_m2 <= v_m1;
			sq_v_s[0] <= v_m2;
			for (int k = 0; k < SQ; k++) sq_v_s[k+1] <= sq_v_s[k];
			vec_v_s[0] <= sq_v_s[SQ];
			for (int k = 0; k < N; k++) vec_v_s[k+1] <= vec_v_s[k];
			v_d1 <= vec_v_s[N];
			out_v_q <= v_d1;
		end
	end

	// s1: raw angle arguments
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= 34'(pair.lat_b) - 34'(pair.lat_a);
			d_s1[1] <= 34'(pair.lon_b) - 34'(pair.lon_a);
			d_s1[2] <= 34'(pair.lat_a) <<< 1;
			d_s1[3] <= 34'(pair.lat_b) <<< 1;
		end
	end

	// s2: wrap into [-180,180), fold into [-90,90]
	always_ff @(posedge clk) begin
		ang_t w, r;
		logic nc;
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				if (d_s1[l] >= DEG_HALF) w = d_s1[l] - DEG_FULL;
				else if (d_s1[l] < -DEG_HALF) w = d_s1[l] + DEG_FULL;
				else w = d_s1[l];
				nc = 1'b1;
				if (w > DEG_QUARTER) r = DEG_HALF - w;
				else if (w < -DEG_QUARTER) r = -DEG_HALF - w;
				else begin
					r = w;
					nc = 1'b0;
				end
				neg_s2[l] <= r[33];
				nc_s2[l] <= nc;
				m_s2[l] <= r[33] ? 30'(-r) : r[29:0];
			end
		end
	end

	// s3..s5: to q30 radians, divide by 180*2^21 via reciprocal of 45
	always_ff @(posedge clk) begin
		logic [68:0] q;
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				p_s3[l] <= 60'(m_s2[l]) * 60'(PI_Q28);
				neg_s3[l] <= neg_s2[l];
				nc_s3[l] <= nc_s2[l];
				t_s4[l] <= 37'((p_s3[l] + RAD_RND) >> 23);
				neg_s4[l] <= neg_s3[l];
				nc_s4[l] <= nc_s3[l];
				q = (69'(t_s4[l][36:32]) * 69'(RECIP45) << 32)
					+ 69'(t_s4[l][31:0]) * 69'(RECIP45);
				e_s5[l] <= 32'(q >> 37);
				t_s5[l] <= t_s4[l];
				neg_s5[l] <= neg_s4[l];
				nc_s5[l] <= nc_s4[l];
			end
		end
	end

	// quotient estimate is exact or one low
	always_ff @(posedge clk) begin
		logic [39:0] rem;
		ang_t zm;
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				rem = 40'(t_s5[l]) - 40'(e_s5[l]) * 40'd45;
				zm = 34'(e_s5[l]) + ((rem >= 40'd45) ? 34'sd1 : 34'sd0);
				rot_z_s[0][l] <= neg_s5[l] ? -zm : zm;
				rot_x_s[0][l] <= CORDIC_K;
				rot_y_s[0][l] <= '0;
				rot_nc_s[0][l] <= nc_s5[l];
			end
		end
	end

	// rotation cordic, one micro-rotation per stage
	for (genvar k = 0; k < N; k++) begin : g_rot
		always_ff @(posedge clk) begin
			ang_t xs, ys;
			if (en) begin
				for (int l = 0; l < 4; l++) begin
					xs = rot_x_s[k][l] >>> k;
					ys = rot_y_s[k][l] >>> k;
					if (!rot_z_s[k][l][33]) begin
						rot_x_s[k+1][l] <= rot_x_s[k][l] - ys;
						rot_y_s[k+1][l] <= rot_y_s[k][l] + xs;
						rot_z_s[k+1][l] <= rot_z_s[k][l] - atan_step(k);
					end else begin
						rot_x_s[k+1][l] <= rot_x_s[k][l] + ys;
						rot_y_s[k+1][l] <= rot_y_s[k][l] - xs;
						rot_z_s[k+1][l] <= rot_z_s[k][l] + atan_step(k);
					end
					rot_nc_s[k+1][l] <= rot_nc_s[k][l];
				end
			end
		end
	end

	// m1, m2: sin^2 terms and cos(lat_a)*cos(lat_b)*sin^2(dlon/2)
	always_ff @(posedge clk) begin
		logic [33:0] au, av;
		ang_t c1, c2;
		logic signed [67:0] pc;
		logic signed [68:0] pt;
		if (en) begin
			au = rot_y_s[N][0][33] ? 34'(-rot_y_s[N][0]) : 34'(rot_y_s[N][0]);
			av = rot_y_s[N][1][33] ? 34'(-rot_y_s[N][1]) : 34'(rot_y_s[N][1]);
			c1 = rot_nc_s[N][2] ? -rot_x_s[N][2] : rot_x_s[N][2];
			c2 = rot_nc_s[N][3] ? -rot_x_s[N][3] : rot_x_s[N][3];
			u2_m1 <= 34'((68'(au) * 68'(au)) >> 30);
			v2_m1 <= 34'((68'(av) * 68'(av)) >> 30);
			pc = 68'(c1) * 68'(c2);
			cc_m1 <= 34'(pc >>> 30);
			pt = 69'(cc_m1) * 69'(signed'({1'b0, v2_m1}));
			t2_m2 <= 34'(pt >>> 30);
			u2_m2 <= u2_m1;
		end
	end

	// h clamped to [0,1], square-root operands h<<30 and (1-h)<<30
	always_ff @(posedge clk) begin
		logic signed [35:0] hs;
		logic [30:0] h;
		if (en) begin
			hs = 36'(signed'({1'b0, u2_m2})) + 36'(t2_m2);
			if (hs < 0) h = '0;
			else if (hs > 36'(ONE_Q30)) h = ONE_Q30;
			else h = 31'(hs);
			sq_n1_s[0] <= 61'(h) << 30;
			sq_n2_s[0] <= 61'(ONE_Q30 - h) << 30;
			sq_r1_s[0] <= '0;
			sq_r2_s[0] <= '0;
		end
	end

	// restoring square root, one result bit per stage
	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		localparam logic [61:0] B = 62'(1) << (2 * (SQ - 1 - k));
		always_ff @(posedge clk) begin
			if (en) begin
				if (62'(sq_n1_s[k]) >= sq_r1_s[k] + B) begin
					sq_n1_s[k+1] <= 61'(62'(sq_n1_s[k]) - sq_r1_s[k] - B);
					sq_r1_s[k+1] <= (sq_r1_s[k] >> 1) + B;
				end else begin
					sq_n1_s[k+1] <= sq_n1_s[k];
					sq_r1_s[k+1] <= sq_r1_s[k] >> 1;
				end
				if (62'(sq_n2_s[k]) >= sq_r2_s[k] + B) begin
					sq_n2_s[k+1] <= 61'(62'(sq_n2_s[k]) - sq_r2_s[k] - B);
					sq_r2_s[k+1] <= (sq_r2_s[k] >> 1) + B;
				end else begin
					sq_n2_s[k+1] <= sq_n2_s[k];
					sq_r2_s[k+1] <= sq_r2_s[k] >> 1;
				end
			end
		end
	end

	// vectoring cordic: z = atan2(sqrt(h), sqrt(1-h))
	always_ff @(posedge clk) begin
		if (en) begin
			vec_x_s[0] <= signed'(34'(sq_r2_s[SQ]));
			vec_y_s[0] <= signed'(34'(sq_r1_s[SQ]));
			vec_z_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_vec
		always_ff @(posedge clk) begin
			ang_t xs, ys;
			if (en) begin
				xs = vec_x_s[k] >>> k;
				ys = vec_y_s[k] >>> k;
				if (vec_y_s[k] > 0) begin
					vec_x_s[k+1] <= vec_x_s[k] + ys;
					vec_y_s[k+1] <= vec_y_s[k] - xs;
					vec_z_s[k+1] <= vec_z_s[k] + atan_step(k);
				end else begin
					vec_x_s[k+1] <= vec_x_s[k] - ys;
					vec_y_s[k+1] <= vec_y_s[k] + xs;
					vec_z_s[k+1] <= vec_z_s[k] - atan_step(k);
				end
			end
		end
	end

	// distance = round(2*asin * 6371 km), saturated at half circumference
	always_ff @(posedge clk) begin
		logic [30:0] zc;
		logic [31:0] dq;
		if (en) begin
			zc = vec_z_s[N][33] ? '0 : vec_z_s[N][30:0];
			dp_d1 <= 46'(zc) * 46'(DIAM_KM) + 46'd8192;
			dq = 32'(dp_d1 >> 14);
			out_dist_q <= (dq > 32'(MAX_DIST)) ? MAX_DIST : 31'(dq);
		end
	end

	`GCD_ASSERT(a_dist_sat, out_v_q |-> (out_dist_q <= MAX_DIST))
	`GCD_ASSERT(a_sqrt_sum, sq_v_s[0] |-> ((sq_n1_s[0] + sq_n2_s[0]) == (61'(ONE_Q30) << 30)))
	`GCD_ASSERT(a_sqrt_floor, sq_v_s[SQ] |-> (62'(sq_n1_s[SQ]) <= (sq_r1_s[SQ] << 1)))
	`GCD_ASSERT_NEXT(a_stall_hold, out_v_q && !res.ready, $stable(sq_n1_s[0]) && $stable(v_s1))

endmodule
